>>> src/pct_pkg.sv
`timescale 1ns / 1ps

package pct_pkg;

    // Escape introducer
    localparam logic [7:0] PCT_CHAR = 8'h25;

    // Output queue geometry
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Most bytes that one input transaction can produce
    localparam int MAX_EMIT = 3;
    localparam int EMIT_W   = $clog2(MAX_EMIT + 1);

    // Decoder phase, one-hot
    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_PCT   = 3'b010,
        PH_DIGIT = 3'b100
    } t_phase;

    // One decoded byte with its end-of-token mark
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_item;

    // Hex digit decode: bit 4 flags a valid digit, bits 3:0 carry its value
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        r = 5'b0_0000;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h41 + 8'd10)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h61 + 8'd10)};
        end
        return r;
    endfunction

endpackage

>>> src/pct_if.sv
`timescale 1ns / 1ps

// Raw token bytes into the decoder
interface pct_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// Decoded bytes out of the decoder
interface pct_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

>>> src/percent_escape_decoder_top.sv
`timescale 1ns / 1ps

// Channel   Modport   Payload               Direction
// i_in      sink      in_byte[7:0] in_last  raw token bytes in
// o_out     source    out_byte[7:0] out_last decoded bytes out
//
// One input transaction per cycle while i_in.ready is high; each is decoded
// in the cycle it is taken and yields zero to three bytes into a four-entry
// output queue. Input is taken while the queue holds at most one byte, so a
// three-byte burst holds i_in.ready low while the queue drains. Output drains
// one byte per cycle; a stall on o_out stops input once two bytes wait.
// Synchronous active-low reset clears phase and queue.

module percent_escape_decoder_top
    import pct_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    pct_in_if.sink       i_in,
    pct_out_if.source    o_out
);

    t_phase             r_phase, n_phase;
    logic [7:0]         r_held, n_held;
    t_item              r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    t_item              e_item [MAX_EMIT];
    logic [EMIT_W-1:0]  n_emit;
    logic               push, pop;
    logic [4:0]         nib_hi, nib_lo;
    logic [7:0]         b;
    logic               l;

    assign b = i_in.in_byte;
    assign l = i_in.in_last;

    // Handshake
    assign i_in.ready  = (r_count <= Q_CNT_W'(1));
    assign push        = i_in.valid && i_in.ready;
    assign o_out.valid = (r_count != '0);
    assign pop         = o_out.valid && o_out.ready;

    assign nib_hi = hex_nibble(r_held);
    assign nib_lo = hex_nibble(b);

    // Decode one byte against the pending phase
    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        n_emit  = '0;
        for (int k = 0; k < MAX_EMIT; k++) begin
            e_item[k] = '{data: b, last: l};
        end
        unique case (r_phase)
            PH_DIGIT: begin
                n_phase = PH_IDLE;
                if (nib_hi[4] && nib_lo[4]) begin
                    e_item[0] = '{data: {nib_hi[3:0], nib_lo[3:0]}, last: l};
                    n_emit    = EMIT_W'(1);
                end else begin
                    e_item[0] = '{data: PCT_CHAR, last: 1'b0};
                    if (r_held == PCT_CHAR) begin
                        // held '%' opens a new escape with this byte
                        if (l) begin
                            e_item[1] = '{data: PCT_CHAR, last: 1'b0};
                            e_item[2] = '{data: b, last: 1'b1};
                            n_emit    = EMIT_W'(3);
                        end else begin
                            n_held  = b;
                            n_phase = PH_DIGIT;
                            n_emit  = EMIT_W'(1);
                        end
                    end else begin
                        e_item[1] = '{data: r_held, last: 1'b0};
                        if (b == PCT_CHAR && !l) begin
                            n_phase = PH_PCT;
                            n_emit  = EMIT_W'(2);
                        end else begin
                            e_item[2] = '{data: b, last: l};
                            n_emit    = EMIT_W'(3);
                        end
                    end
                end
            end
            PH_PCT: begin
                if (l) begin
                    e_item[0] = '{data: PCT_CHAR, last: 1'b0};
                    e_item[1] = '{data: b, last: 1'b1};
                    n_emit    = EMIT_W'(2);
                    n_phase   = PH_IDLE;
                end else begin
                    n_held  = b;
                    n_phase = PH_DIGIT;
                end
            end
            default: begin
                if (b == PCT_CHAR && !l) begin
                    n_phase = PH_PCT;
                end else begin
                    n_emit  = EMIT_W'(1);
                    n_phase = PH_IDLE;
                end
            end
        endcase
    end

    // Hold decoder state, advance on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= '0;
        end else if (push) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

    // Write decoded bytes into the output queue
    always_ff @(posedge i_clk) begin
        if (push) begin
            for (int k = 0; k < MAX_EMIT; k++) begin
                if (EMIT_W'(k) < n_emit) begin
                    r_q[r_wr_ptr + Q_PTR_W'(k)] <= e_item[k];
                end
            end
        end
    end

    // Advance queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(n_emit);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            r_count <= r_count + (push ? Q_CNT_W'(n_emit) : Q_CNT_W'(0))
                       - (pop ? Q_CNT_W'(1) : Q_CNT_W'(0));
        end
    end

    assign o_out.out_byte = r_q[r_rd_ptr].data;
    assign o_out.out_last = r_q[r_rd_ptr].last;

    // Queue never overfills
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CNT_W'(Q_DEPTH))
        else $error("output queue overfilled");

    // Nothing stays pending after the end of a token
    a_token_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && i_in.in_last |=> r_phase == PH_IDLE)
        else $error("escape left pending after last byte");

    // A pop with no push removes exactly one entry
    a_pop_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !push |=> r_count == $past(r_count) - Q_CNT_W'(1))
        else $error("fill count out of step with pop");

    // A drained queue delivers nothing
    a_empty_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == '0 && !push |=> !o_out.valid)
        else $error("output valid from empty queue");

endmodule

>>> tb/tb_percent_escape_decoder_top.sv
`timescale 1ns / 1ps

module tb_percent_escape_decoder_top;
    import pct_pkg::*;

    // Tracks decoder phase and the decoded bytes still owed by the block
    class decoded_byte_checker;
        t_phase     phase;
        logic [7:0] held_byte;
        t_item      owed_bytes[$];
        int         errors;

        function new();
            phase     = PH_IDLE;
            held_byte = 8'h00;
            errors    = 0;
        endfunction

        // Bit 4 set when the byte is a hex digit, value in bits 3:0
        function automatic logic [4:0] digit_of(logic [7:0] c);
            logic [7:0] folded;
            folded = c | 8'h20;
            if (c >= "0" && c <= "9") begin
                return {1'b1, c[3:0]};
            end
            if (folded >= "a" && folded <= "f") begin
                return {1'b1, 4'(folded - "a" + 8'd10)};
            end
            return 5'b0_0000;
        endfunction

        function void owe(logic [7:0] b, logic l);
            t_item it;
            it.data = b;
            it.last = l;
            owed_bytes = {owed_bytes, it};
        endfunction

        // Byte handled with no first digit held
        function void decode_plain(logic [7:0] b, logic l);
            if (phase == PH_PCT) begin
                if (l) begin
                    owe(PCT_CHAR, 1'b0);
                    owe(b, 1'b1);
                    phase = PH_IDLE;
                end else begin
                    held_byte = b;
                    phase     = PH_DIGIT;
                end
                return;
            end
            phase = PH_IDLE;
            if (b == PCT_CHAR && !l) begin
                phase = PH_PCT;
            end else begin
                owe(b, l);
            end
        endfunction

        // Note one accepted raw byte and work out what it decodes to
        function void note_raw_byte(logic [7:0] b, logic l);
            logic [4:0] hi;
            logic [4:0] lo;
            if (phase == PH_DIGIT) begin
                hi    = digit_of(held_byte);
                lo    = digit_of(b);
                phase = PH_IDLE;
                if (hi[4] && lo[4]) begin
                    owe({hi[3:0], lo[3:0]}, l);
                end else begin
                    // Bad escape: emit the percent, run both bytes through again
                    owe(PCT_CHAR, 1'b0);
                    decode_plain(held_byte, 1'b0);
                    decode_plain(b, l);
                end
            end else begin
                decode_plain(b, l);
            end
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH @%0t: %s", $realtime, msg);
        endtask

        // Compare one decoded byte against the oldest owed byte
        task check_decoded_byte(logic [7:0] b, logic l);
            t_item want;
            if (owed_bytes.size() == 0) begin
                report($sformatf("unexpected byte %02h last %0b", b, l));
                return;
            end
            want = owed_bytes.pop_front();
            if (b !== want.data) begin
                report($sformatf("byte %02h, want %02h", b, want.data));
            end
            if (l !== want.last) begin
                report($sformatf("last %0b on byte %02h, want %0b", l, b, want.last));
            end
        endtask

        function int outstanding();
            return owed_bytes.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    pct_in_if  in_ch ();
    pct_out_if out_ch ();

    percent_escape_decoder_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    decoded_byte_checker checker_h = new();

    int burst_left;
    int sent_count;
    int ready_left;
    int ready_mode;
    int ready_pos;
    logic [7:0] ready_mask;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop
    initial begin
        #1ms;
        $display("Regression FAIL");
        $finish;
    end

    // Receiver: check accepted bytes, stall on a changing pattern
    initial begin
        out_ch.ready <= 1'b0;
        ready_left = 0;
        ready_pos  = 0;
        ready_mode = 0;
        ready_mask = 8'hFF;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                checker_h.check_decoded_byte(out_ch.out_byte, out_ch.out_last);
            end
            if (ready_left == 0) begin
                ready_left = $urandom_range(20, 80);
                ready_mode = $urandom_range(0, 2);
                case (ready_mode)
                    0: ready_mask = 8'hFF;
                    1: ready_mask = 8'($urandom());
                    default: ready_mask = 8'h01 << $urandom_range(0, 7);
                endcase
            end
            ready_left--;
            ready_pos++;
            out_ch.ready <= ready_mask[ready_pos % 8];
        end
    end

    // Send one raw byte, opening a new burst after a random gap when due
    task automatic send_raw(logic [7:0] b, logic l);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_ch.valid   <= 1'b0;
                in_ch.in_byte <= 8'($urandom());
                in_ch.in_last <= 1'($urandom());
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.in_last <= l;
        do @(posedge i_clk); while (!in_ch.ready);
        checker_h.note_raw_byte(b, l);
        burst_left--;
        sent_count++;
    endtask

    // Send a whole token, last mark on its final character
    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            send_raw(s[i], i == s.len() - 1);
        end
    endtask

    // Hold input until every owed byte has come out
    task automatic wait_quiet();
        in_ch.valid <= 1'b0;
        while (checker_h.outstanding() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [7:0] hex_char();
        int k;
        k = $urandom_range(0, 21);
        if (k < 10) return 8'("0" + k);
        if (k < 16) return 8'("A" + k - 10);
        return 8'("a" + k - 16);
    endfunction

    // Bytes just outside the digit ranges, and the byte extremes
    function automatic logic [7:0] boundary_char();
        case ($urandom_range(0, 7))
            0: return 8'h2F;
            1: return 8'h3A;
            2: return 8'h40;
            3: return 8'h47;
            4: return 8'h60;
            5: return 8'h67;
            6: return 8'h00;
            default: return 8'hFF;
        endcase
    endfunction

    // Mostly well-formed escapes with random content, plus broken ones and noise
    task automatic send_random_token();
        logic [7:0] tok[$];
        int n;
        int k;
        n = $urandom_range(1, 10);
        while (tok.size() < n) begin
            k = $urandom_range(0, 99);
            if (k < 45) begin
                tok = {tok, PCT_CHAR, hex_char(), hex_char()};
            end else if (k < 55) begin
                tok = {tok, PCT_CHAR};
            end else if (k < 70) begin
                tok = {tok, hex_char()};
            end else if (k < 80) begin
                tok = {tok, boundary_char()};
            end else begin
                tok = {tok, 8'($urandom())};
            end
        end
        foreach (tok[i]) begin
            send_raw(tok[i], i == tok.size() - 1);
        end
    endtask

    // Stimulus
    initial begin
        int waited;
        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.in_byte <= 8'h00;
        in_ch.in_last <= 1'b0;
        burst_left = 0;
        sent_count = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: byte extremes, plain and truncated escapes, bad digits
        send_raw(8'h00, 1'b0);
        send_raw(8'hFF, 1'b1);
        send_text("%41");
        send_text("%6a");
        send_text("%");
        send_text("%Z");
        send_text("%G1");
        send_text("%%41");
        send_text("%4%0f");
        wait_quiet();

        // Random tokens, draining now and then
        while (sent_count < 225) begin
            send_random_token();
            if ($urandom_range(0, 15) == 0) begin
                wait_quiet();
            end
        end

        // Drain and finish
        in_ch.valid <= 1'b0;
        waited = 0;
        while (checker_h.outstanding() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        if (checker_h.outstanding() != 0) begin
            checker_h.report($sformatf("%0d decoded bytes never arrived",
                                       checker_h.outstanding()));
        end
        if (checker_h.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
src/pct_pkg.sv
src/pct_if.sv
src/percent_escape_decoder_top.sv
tb/tb_percent_escape_decoder_top.sv
